FILE: rtl/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncc_pkg;

   localparam int unsigned MAX_NEST_DEPTH = 255;
   localparam int unsigned NEST_W         = $clog2(MAX_NEST_DEPTH + 1);
   localparam logic [NEST_W-1:0] DEPTH_MAX = NEST_W'(MAX_NEST_DEPTH);
   localparam logic [NEST_W-1:0] DEPTH_ONE = NEST_W'(1);

   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_STAR  = 8'h2a;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_NL    = 8'h0a;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      CLS_CODE    = 3'd0,
      CLS_BLANK   = 3'd1,
      CLS_NEWLINE = 3'd2,
      CLS_LINE    = 3'd3,
      CLS_BLOCK   = 3'd4,
      CLS_DOC     = 3'd5,
      CLS_MODDOC  = 3'd6
   } byte_class_type;

   typedef enum logic [1:0] {
      PREV_NONE   = 2'd0,
      PREV_SLASH  = 2'd1,
      PREV_STAR   = 2'd2,
      PREV_OPENER = 2'd3
   } block_prev_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_word_type;

   typedef struct packed {
      logic [7:0]     out_byte;
      byte_class_type byte_class;
      logic           last_of_run;
      logic           unterminated;
      logic           depth_overflow;
   } rsp_word_type;

   // held slashes released ahead of the byte that decided them
   typedef struct packed {
      logic [1:0]     slash_count;
      byte_class_type slash_class;
      logic           slash_overflow;
      rsp_word_type   tail;
   } group_type;

endpackage

`default_nettype wire

FILE: rtl/ncc_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module ncc_scan (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  ncc_pkg::req_word_type req_word,
   input  wire                  req_stall,
   output logic                 grp_push,
   output ncc_pkg::group_type   grp_word
);
   import ncc_pkg::*;

   logic [1:0]        held_count_ff, held_count_in;
   byte_class_type    scan_mode_ff, scan_mode_in;
   logic [NEST_W-1:0] nest_depth_ff, nest_depth_in;
   block_prev_type    block_prev_ff, block_prev_in;
   logic              overflow_seen_ff, overflow_seen_in;

   logic              accept;
   logic [7:0]        c;
   logic              fin;
   logic              hold;
   byte_class_type    slash_class;
   byte_class_type    tail_class;
   byte_class_type    mode_mid, mode_nx;
   logic [NEST_W-1:0] depth_mid, depth_nx, depth_dec;
   block_prev_type    prev_mid, prev_nx;
   logic              ovf_nx;

   assign accept = req_valid && !req_stall;
   assign c      = req_word.in_byte;
   assign fin    = req_word.is_final;
   assign hold   = !fin && (c == CHAR_SLASH) && (scan_mode_ff == CLS_CODE)
                   && (held_count_ff != 2'd3);

   // decide the held slashes
   always_comb begin
      mode_mid    = scan_mode_ff;
      depth_mid   = nest_depth_ff;
      prev_mid    = block_prev_ff;
      slash_class = CLS_CODE;
      case (held_count_ff)
         2'd1: begin
            if (c == CHAR_STAR) begin
               mode_mid    = CLS_BLOCK;
               depth_mid   = DEPTH_ONE;
               prev_mid    = PREV_OPENER;
               slash_class = CLS_BLOCK;
            end else if (c == CHAR_SLASH) begin
               mode_mid    = CLS_LINE;
               slash_class = CLS_LINE;
            end else begin
               slash_class = CLS_CODE;
            end
         end
         2'd2: begin
            if (c == CHAR_BANG) begin
               mode_mid    = CLS_MODDOC;
               slash_class = CLS_MODDOC;
            end else if (c == CHAR_SLASH) begin
               mode_mid    = CLS_DOC;
               slash_class = CLS_DOC;
            end else begin
               mode_mid    = CLS_LINE;
               slash_class = CLS_LINE;
            end
         end
         2'd3: begin
            if (c == CHAR_SLASH) begin
               mode_mid    = CLS_LINE;
               slash_class = CLS_LINE;
            end else begin
               mode_mid    = CLS_DOC;
               slash_class = CLS_DOC;
            end
         end
         default: begin
            slash_class = CLS_CODE;
         end
      endcase
   end

   // classify the new byte
   always_comb begin
      mode_nx    = mode_mid;
      depth_nx   = depth_mid;
      prev_nx    = prev_mid;
      ovf_nx     = overflow_seen_ff;
      tail_class = CLS_CODE;
      depth_dec  = (depth_mid != '0) ? depth_mid - DEPTH_ONE : depth_mid;
      case (mode_mid)
         CLS_BLOCK: begin
            tail_class = CLS_BLOCK;
            if (prev_mid == PREV_OPENER) begin
               prev_nx = PREV_NONE;
            end else if (prev_mid == PREV_SLASH && c == CHAR_STAR) begin
               if (depth_mid >= DEPTH_MAX) begin
                  depth_nx = DEPTH_MAX;
                  ovf_nx   = 1'b1;
               end else begin
                  depth_nx = depth_mid + DEPTH_ONE;
               end
               prev_nx = PREV_NONE;
            end else if (prev_mid == PREV_STAR && c == CHAR_SLASH) begin
               depth_nx = depth_dec;
               prev_nx  = PREV_NONE;
               if (depth_dec == '0) begin
                  mode_nx = CLS_CODE;
               end
            end else if (c == CHAR_SLASH) begin
               prev_nx = PREV_SLASH;
            end else if (c == CHAR_STAR) begin
               prev_nx = PREV_STAR;
            end else begin
               prev_nx = PREV_NONE;
            end
         end
         CLS_LINE, CLS_DOC, CLS_MODDOC: begin
            if (c == CHAR_NL) begin
               tail_class = CLS_NEWLINE;
               mode_nx    = CLS_CODE;
            end else begin
               tail_class = mode_mid;
            end
         end
         default: begin
            if (c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR}) begin
               tail_class = CLS_BLANK;
            end else if (c == CHAR_NL) begin
               tail_class = CLS_NEWLINE;
            end else begin
               tail_class = CLS_CODE;
               mode_nx    = CLS_CODE;
            end
         end
      endcase
   end

   always_comb begin
      grp_push                     = accept && !hold;
      grp_word.slash_count         = held_count_ff;
      grp_word.slash_class         = slash_class;
      grp_word.slash_overflow      = overflow_seen_ff;
      grp_word.tail.out_byte       = c;
      grp_word.tail.byte_class     = tail_class;
      grp_word.tail.last_of_run    = fin;
      grp_word.tail.unterminated   = fin && (mode_nx == CLS_BLOCK);
      grp_word.tail.depth_overflow = ovf_nx;
   end

   always_comb begin
      held_count_in    = held_count_ff;
      scan_mode_in     = scan_mode_ff;
      nest_depth_in    = nest_depth_ff;
      block_prev_in    = block_prev_ff;
      overflow_seen_in = overflow_seen_ff;
      if (accept) begin
         if (fin) begin
            held_count_in    = 2'd0;
            scan_mode_in     = CLS_CODE;
            nest_depth_in    = '0;
            block_prev_in    = PREV_NONE;
            overflow_seen_in = 1'b0;
         end else if (hold) begin
            held_count_in = held_count_ff + 2'd1;
         end else begin
            held_count_in    = 2'd0;
            scan_mode_in     = mode_nx;
            nest_depth_in    = depth_nx;
            block_prev_in    = prev_nx;
            overflow_seen_in = ovf_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff    <= 2'd0;
         scan_mode_ff     <= CLS_CODE;
         nest_depth_ff    <= '0;
         block_prev_ff    <= PREV_NONE;
         overflow_seen_ff <= 1'b0;
      end else begin
         held_count_ff    <= held_count_in;
         scan_mode_ff     <= scan_mode_in;
         nest_depth_ff    <= nest_depth_in;
         block_prev_ff    <= block_prev_in;
         overflow_seen_ff <= overflow_seen_in;
      end
   end

   // slashes are only held back in code
   assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> scan_mode_ff == CLS_CODE)
      else $error("slashes held outside code");

   assert property (@(posedge clock) disable iff (reset)
      scan_mode_ff == CLS_BLOCK |-> nest_depth_ff != '0)
      else $error("block comment with zero depth");

   assert property (@(posedge clock) disable iff (reset)
      scan_mode_ff != CLS_BLOCK |-> nest_depth_ff == '0)
      else $error("nonzero depth outside block comment");

endmodule

`default_nettype wire

FILE: rtl/ncc_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ncc_out_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  grp_push,
   input  ncc_pkg::group_type   grp_word,
   output logic                 full_stall,
   output logic                 rsp_valid,
   output ncc_pkg::rsp_word_type rsp_word,
   input  wire                  rsp_stall
);
   import ncc_pkg::*;

   group_type  slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] pos_ff, pos_in;

   group_type  head;
   logic       at_tail;
   logic       take;
   logic       pop;

   assign head       = slot_ff[rd_ptr_ff];
   assign at_tail    = (pos_ff == head.slash_count);
   assign rsp_valid  = (count_ff != 2'd0);
   assign take       = rsp_valid && !rsp_stall;
   assign pop        = take && at_tail;
   assign full_stall = (count_ff == 2'd2) && !pop;

   always_comb begin
      if (at_tail) begin
         rsp_word = head.tail;
      end else begin
         rsp_word = '{out_byte:       CHAR_SLASH,
                      byte_class:     head.slash_class,
                      last_of_run:    1'b0,
                      unterminated:   1'b0,
                      depth_overflow: head.slash_overflow};
      end
   end

   always_comb begin
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = grp_push ? !wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, grp_push} - {1'b0, pop};
      pos_in    = pos_ff;
      if (take) begin
         pos_in = at_tail ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         pos_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_push) begin
         slot_ff[wr_ptr_ff] <= grp_word;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("group queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pos_ff <= head.slash_count)
      else $error("word position past end of group");

endmodule

`default_nettype wire

FILE: rtl/nested_comment_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Tags each source byte with its class (code, blank, newline, line comment, block comment,
// doc comment, module doc comment) and returns it in input order, one word per byte.
// One byte is accepted per unstalled cycle and its word can leave the cycle after
// acceptance. A code '/' is held until up to three more bytes settle what it opens; the
// up to three held slashes leave ahead of the deciding byte, a burst of up to four words.
// Words sit in a two-group output queue, so input keeps flowing while a result waits, and
// req_stall rises only while both groups are occupied and the head group is not leaving.
// Block comments nest up to MAX_NEST_DEPTH; depth_overflow stays set once that is passed,
// until the end of the text. A word marked is_final ends the text, flushes held slashes,
// flags an open block comment on the last word and returns the scanner to its reset state.

module nested_comment_classifier (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  ncc_pkg::req_word_type req_word,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output ncc_pkg::rsp_word_type rsp_word,
   input  wire                   rsp_stall
);
   import ncc_pkg::*;

   logic      grp_push;
   group_type grp_word;
   logic      full_stall;

   assign req_stall = full_stall;

   ncc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (full_stall),
      .grp_push  (grp_push),
      .grp_word  (grp_word)
   );

   ncc_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .grp_push   (grp_push),
      .grp_word   (grp_word),
      .full_stall (full_stall),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .rsp_stall  (rsp_stall)
   );

endmodule

`default_nettype wire
